// File: rtl/lsd_pkg.sv
`default_nettype none

package lsd_pkg;

  localparam int COLOR_W = 24;
  localparam int DIM_W   = 13;
  localparam int ROW_W   = 12;
  localparam int BANKS   = 4;
  localparam int BANK_W  = 2;
  localparam int IDX_W   = 2;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [BANK_W-1:0]  bank_t;
  typedef logic [IDX_W-1:0]   cfg_idx_t;

  localparam color_t BLACK = '0;

  localparam dim_t RESET_DIM  = 13'd256;
  localparam dim_t MAX_HEIGHT = 13'd4096;

  // register indexes of the configuration port
  localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
  localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;

  // input kind
  localparam logic FUNC_TEXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic   no_surface;
    color_t color;
  } texel_t;

  // one item slot moving down the pass chain
  typedef struct packed {
    logic   valid;  // slot carries a transaction
    logic   has;    // slot carries a texel
    logic   last;   // texel is the final one of its frame
    texel_t data;
  } tick_t;

endpackage

`default_nettype wire

// File: rtl/lsd_bank.sv
`default_nettype none

// one row bank: one write, two registered reads
module lsd_bank #(
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire lsd_pkg::texel_t          wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output lsd_pkg::texel_t               rdata0,
  output lsd_pkg::texel_t               rdata1
);

  lsd_pkg::texel_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

`default_nettype wire

// File: rtl/lsd_cell.sv
`default_nettype none

// one dilation pass: line banks, emit control, 3x3 pick
module lsd_cell #(
  parameter int MAX_WIDTH = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           clr,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0] img_w,
  input  wire lsd_pkg::dim_t                  img_h,
  input  wire lsd_pkg::tick_t                 tick_in,
  output lsd_pkg::tick_t                      tick_out
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = $clog2(MAX_WIDTH + 3);

  // input side position
  logic [XW-1:0]          xi_r, xi_nxt;
  lsd_pkg::row_t          yi_r, yi_nxt;
  lsd_pkg::bank_t         gi_r, gi_nxt;
  // emit side position
  logic [XW-1:0]          xo_r, xo_nxt;
  lsd_pkg::row_t          yo_r, yo_nxt;
  lsd_pkg::bank_t         go_r, go_nxt;
  // texels held, and whether the emit frame is complete
  logic [LW-1:0]          lag_r, lag_nxt, lag_post;
  logic                   done_r, done_nxt;

  logic                   has_a, emit_a, recv_last, emit_last;
  logic                   xi_last, yi_last, xo_last, yo_last;
  logic [WW-1:0]          w_m1;
  lsd_pkg::dim_t          h_m1;
  logic [XW-1:0]          xo_p1;

  lsd_pkg::texel_t        rdc [lsd_pkg::BANKS];
  lsd_pkg::texel_t        rdr [lsd_pkg::BANKS];

  // second stage
  logic                   vb_r, eb_r, lastb_r;
  logic                   lv_r, rv_r, tv_r, bv_r, hitc_r, hitr_r;
  lsd_pkg::bank_t         gob_r, wbank_r;
  lsd_pkg::texel_t        wdata_r;
  lsd_pkg::texel_t        l_r [3];
  lsd_pkg::texel_t        cvb [lsd_pkg::BANKS];
  lsd_pkg::texel_t        rvb [lsd_pkg::BANKS];
  lsd_pkg::texel_t        col_c [3];
  lsd_pkg::texel_t        col_r [3];
  lsd_pkg::texel_t        res;
  lsd_pkg::tick_t         out_r;

  assign w_m1    = img_w - 1'b1;
  assign h_m1    = img_h - 1'b1;
  assign xo_p1   = xo_r + 1'b1;
  assign xi_last = (WW'(xi_r) == w_m1);
  assign yi_last = (lsd_pkg::dim_t'(yi_r) == h_m1);
  assign xo_last = (WW'(xo_r) == w_m1);
  assign yo_last = (lsd_pkg::dim_t'(yo_r) == h_m1);

  assign has_a     = tick_in.valid && tick_in.has;
  assign recv_last = has_a && xi_last && yi_last;
  assign emit_last = xo_last && yo_last;
  assign lag_post  = lag_r + LW'(has_a);

  // emit once W+1 texels follow, or once the whole frame is in
  assign emit_a = tick_in.valid && (lag_post != '0) &&
                  ((lag_post >= (LW'(img_w) + LW'(2))) || done_r || recv_last);

  always_comb begin
    xi_nxt = xi_r;
    yi_nxt = yi_r;
    gi_nxt = gi_r;
    xo_nxt = xo_r;
    yo_nxt = yo_r;
    go_nxt = go_r;
    if (has_a) begin
      if (xi_last) begin
        xi_nxt = '0;
        gi_nxt = gi_r + 1'b1;
        yi_nxt = yi_last ? '0 : lsd_pkg::row_t'(yi_r + 1'b1);
      end else begin
        xi_nxt = xi_r + 1'b1;
      end
    end
    if (emit_a) begin
      if (xo_last) begin
        xo_nxt = '0;
        go_nxt = go_r + 1'b1;
        yo_nxt = yo_last ? '0 : lsd_pkg::row_t'(yo_r + 1'b1);
      end else begin
        xo_nxt = xo_p1;
      end
    end
    lag_nxt  = lag_post - LW'(emit_a);
    done_nxt = (done_r && !(emit_a && emit_last)) || recv_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      xi_r   <= '0;
      yi_r   <= '0;
      gi_r   <= '0;
      xo_r   <= '0;
      yo_r   <= '0;
      go_r   <= '0;
      lag_r  <= '0;
      done_r <= 1'b0;
    end else if (en) begin
      xi_r   <= xi_nxt;
      yi_r   <= yi_nxt;
      gi_r   <= gi_nxt;
      xo_r   <= xo_nxt;
      yo_r   <= yo_nxt;
      go_r   <= go_nxt;
      lag_r  <= lag_nxt;
      done_r <= done_nxt;
    end
  end

  // banks hold rows by global row count mod 4; every bank reads
  // the center and right columns, stage two picks by row
  for (genvar b = 0; b < lsd_pkg::BANKS; b++) begin : g_bank
    lsd_bank #(
      .DEPTH (MAX_WIDTH)
    ) u_bank (
      .clk    (clk),
      .we     (en && has_a && (gi_r == lsd_pkg::bank_t'(b))),
      .waddr  (xi_r),
      .wdata  (tick_in.data),
      .re     (en),
      .raddr0 (xo_r),
      .raddr1 (xo_p1),
      .rdata0 (rdc[b]),
      .rdata1 (rdr[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vb_r <= 1'b0;
      eb_r <= 1'b0;
    end else if (en) begin
      vb_r <= tick_in.valid;
      eb_r <= emit_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lastb_r <= emit_last;
      lv_r    <= (xo_r != '0);
      rv_r    <= !xo_last;
      tv_r    <= (yo_r != '0);
      bv_r    <= !yo_last;
      gob_r   <= go_r;
      // the arriving texel may be one of this cycle's reads
      hitc_r  <= has_a && (xi_r == xo_r);
      hitr_r  <= has_a && (xi_r == xo_p1);
      wbank_r <= gi_r;
      wdata_r <= tick_in.data;
    end
  end

  always_comb begin
    for (int b = 0; b < lsd_pkg::BANKS; b++) begin
      cvb[b] = (hitc_r && (wbank_r == lsd_pkg::bank_t'(b))) ? wdata_r : rdc[b];
      rvb[b] = (hitr_r && (wbank_r == lsd_pkg::bank_t'(b))) ? wdata_r : rdr[b];
    end
    col_c[0] = cvb[lsd_pkg::bank_t'(gob_r - 1'b1)];
    col_c[1] = cvb[gob_r];
    col_c[2] = cvb[lsd_pkg::bank_t'(gob_r + 1'b1)];
    col_r[0] = rvb[lsd_pkg::bank_t'(gob_r - 1'b1)];
    col_r[1] = rvb[gob_r];
    col_r[2] = rvb[lsd_pkg::bank_t'(gob_r + 1'b1)];
  end

  // column-major scan: left column, center top/bottom, right column
  always_comb begin
    lsd_pkg::texel_t cand [8];
    logic            cok  [8];
    lsd_pkg::texel_t ctr;
    logic            found;
    lsd_pkg::color_t pick;
    cand[0] = l_r[0];   cok[0] = lv_r && tv_r;
    cand[1] = l_r[1];   cok[1] = lv_r;
    cand[2] = l_r[2];   cok[2] = lv_r && bv_r;
    cand[3] = col_c[0]; cok[3] = tv_r;
    cand[4] = col_c[2]; cok[4] = bv_r;
    cand[5] = col_r[0]; cok[5] = rv_r && tv_r;
    cand[6] = col_r[1]; cok[6] = rv_r;
    cand[7] = col_r[2]; cok[7] = rv_r && bv_r;
    ctr   = col_c[1];
    found = 1'b0;
    pick  = lsd_pkg::BLACK;
    for (int i = 7; i >= 0; i--) begin
      if (cok[i] && (cand[i].color != lsd_pkg::BLACK)) begin
        found = 1'b1;
        pick  = cand[i].color;
      end
    end
    res = ctr;
    if (ctr.no_surface && (ctr.color == lsd_pkg::BLACK) && found) begin
      res.color = pick;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      out_r.valid <= 1'b0;
      out_r.has   <= 1'b0;
    end else if (en) begin
      out_r.valid <= vb_r;
      out_r.has   <= vb_r && eb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.last <= lastb_r;
      out_r.data <= res;
      if (vb_r && eb_r) begin
        for (int i = 0; i < 3; i++) begin
          l_r[i] <= col_c[i];
        end
      end
    end
  end

  assign tick_out = out_r;

endmodule

`default_nettype wire

// File: rtl/lightmap_seam_dilation.sv
// Path: input slot, per pass the bank reads and output slot, then the output register.
//   Per pass, texel p is released by texel p+W+1 or once its frame's last texel is in.
// Throughput: one transaction per cycle in and out while the skid register is empty;
//   each pass reads its row banks once per cycle, so nothing repeats per item.
// Reset (rst_n low, synchronous): pipeline and counters cleared, width and height 256.
//   Line banks are not cleared; a width or height write clears the cells and input slot.
`default_nettype none

module lightmap_seam_dilation #(
  parameter int MAX_WIDTH = 4096,
  parameter int PASSES    = 2
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // configuration
  input  wire logic                     cfg_we,
  input  wire lsd_pkg::cfg_idx_t        cfg_index,
  input  wire lsd_pkg::dim_t            cfg_wdata,
  // input stream
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [31:0]              in_tdata,   // [23:0] texel_color, [24] no_surface
  input  wire logic                     in_tuser,   // [0] func: 0 texel, 1 flush
  // result stream
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [23:0]                   out_tdata,  // [23:0] out_color
  output logic                          out_tlast   // last_of_frame
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int RST_W = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;

  logic [WW-1:0]   width_r, w_clamp;
  lsd_pkg::dim_t   height_r, h_clamp;
  logic            clr;
  logic            en;

  lsd_pkg::tick_t  in_tick_r;
  lsd_pkg::tick_t  chain [PASSES+1];

  logic            res_valid;
  lsd_pkg::color_t out_color_r, skid_color_r;
  logic            out_last_r, skid_last_r;
  logic            out_valid_r, skid_valid_r;

  // ---------------------------------------------------------------
  // Configuration: out-of-range sizes are clamped when written.
  // A write to a real register restarts the frame at row 0, column 0.
  // ---------------------------------------------------------------
  always_comb begin
    priority if (cfg_wdata == '0) begin
      w_clamp = WW'(1);
    end else if (cfg_wdata > lsd_pkg::dim_t'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(cfg_wdata);
    end
    priority if (cfg_wdata == '0) begin
      h_clamp = lsd_pkg::dim_t'(1);
    end else if (cfg_wdata > lsd_pkg::MAX_HEIGHT) begin
      h_clamp = lsd_pkg::MAX_HEIGHT;
    end else begin
      h_clamp = cfg_wdata;
    end
  end

  assign clr = cfg_we && ((cfg_index == lsd_pkg::REG_IMAGE_WIDTH) ||
                          (cfg_index == lsd_pkg::REG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(RST_W);
      height_r <= lsd_pkg::RESET_DIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lsd_pkg::REG_IMAGE_WIDTH:  width_r  <= w_clamp;
        lsd_pkg::REG_IMAGE_HEIGHT: height_r <= h_clamp;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // The whole chain advances together. It holds only while the skid
  // register is full, which is a registered condition, so in_tready
  // never depends combinationally on out_tready.
  // ---------------------------------------------------------------
  assign en        = !skid_valid_r;
  assign in_tready = en;

  // input slot: flush transactions travel as empty slots
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      in_tick_r.valid <= 1'b0;
      in_tick_r.has   <= 1'b0;
    end else if (en) begin
      in_tick_r.valid <= in_tvalid;
      in_tick_r.has   <= in_tvalid && (in_tuser == lsd_pkg::FUNC_TEXEL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_tick_r.last       <= 1'b0;
      in_tick_r.data.color <= in_tdata[23:0];
      in_tick_r.data.no_surface <= in_tdata[24];
    end
  end

  assign chain[0] = in_tick_r;

  // one cell per pass; each feeds its output slots to the next pass
  for (genvar k = 0; k < PASSES; k++) begin : g_pass
    lsd_cell #(
      .MAX_WIDTH (MAX_WIDTH)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .clr      (clr),
      .img_w    (width_r),
      .img_h    (height_r),
      .tick_in  (chain[k]),
      .tick_out (chain[k+1])
    );
  end

  // ---------------------------------------------------------------
  // Output register plus skid register. A result taken while the
  // output register is stalled lands in the skid slot and holds the chain.
  // ---------------------------------------------------------------
  assign res_valid = en && chain[PASSES].valid && chain[PASSES].has;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_tready) begin
        if (skid_valid_r) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r  <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_color_r <= skid_color_r;
        out_last_r  <= skid_last_r;
      end else begin
        out_color_r <= chain[PASSES].data.color;
        out_last_r  <= chain[PASSES].last;
      end
    end else if (res_valid) begin
      skid_color_r <= chain[PASSES].data.color;
      skid_last_r  <= chain[PASSES].last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// File: tb/lightmap_seam_dilation_tb.sv
`default_nettype none

module lightmap_seam_dilation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsd_pkg::*;

  localparam int MAX_W        = 4096;
  localparam int PASSES       = 2;
  localparam int RING         = 4 * MAX_W;          // line store entries per pass
  localparam int CLK_PERIOD   = 4;
  localparam int RESET_CYCLES = 9;
  localparam int LATENCY      = 1 + 2 * PASSES;
  localparam int HOLD_CYCLES  = 400;                // long receiver hold-off
  localparam int RANDOM_TEXELS = 1000;
  localparam int RANDOM_FRAME_MAX = 256;            // largest random frame
  localparam int EXTREME_TEXELS = 100;              // texels sent at the largest sizes
  localparam int END_GUARD    = 20000;
  localparam longint LIMIT_CYCLES = 2_000_000;

  // register indexes past the last register: writes to them must do nothing
  localparam cfg_idx_t REG_UNUSED_2 = 2'd2;
  localparam cfg_idx_t REG_UNUSED_3 = 2'd3;

  typedef struct {
    color_t color;
    logic   last;
  } seam_texel_t;

  // DUT inputs, all known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_idx_t    cfg_index = REG_IMAGE_WIDTH;
  dim_t        cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [23:0] texel_color, [24] no_surface
  logic        in_tuser = FUNC_TEXEL; // [0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [23:0] out_color
  logic        out_tlast;       // last_of_frame

  lightmap_seam_dilation #(
    .MAX_WIDTH(MAX_W),
    .PASSES   (PASSES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Dilation predictor: per pass a ring of colour+flag words and two counters
  // (texels taken in, texels emitted). Each pass emits texel e once texel
  // e+W+1 is in, or once the whole frame of e is in.
  // ---------------------------------------------------------------------------
  logic [24:0]     pass_store [PASSES][RING];
  longint unsigned rcv_cnt [PASSES];
  longint unsigned emt_cnt [PASSES];
  dim_t            width_reg  = RESET_DIM;
  dim_t            height_reg = RESET_DIM;

  seam_texel_t dilated_texels[$];   // results still owed by the DUT
  int          fail_count = 0;

  function automatic int unsigned act_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_W) return MAX_W;
    return int'(width_reg);
  endfunction

  function automatic int unsigned act_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return int'(MAX_HEIGHT);
    return int'(height_reg);
  endfunction

  function automatic void clear_passes();
    for (int k = 0; k < PASSES; k++) begin
      rcv_cnt[k] = 0;
      emt_cnt[k] = 0;
    end
  endfunction

  function automatic bit passes_drained();
    for (int k = 0; k < PASSES; k++)
      if (rcv_cnt[k] != emt_cnt[k]) return 1'b0;
    return 1'b1;
  endfunction

  // One pass for one transaction; returns 1 when it emits a texel.
  function automatic bit dilate_pass(input int k, input bit has_in, input logic [24:0] din,
                                     output logic [24:0] dout);
    longint unsigned w, n, e, frame_end, need, pos;
    longint x, y, nx, ny, q, dx, dy;
    logic [24:0] c, nb;
    bit found;
    dout = '0;
    if (has_in) begin
      pass_store[k][rcv_cnt[k] % RING] = din;
      rcv_cnt[k]++;
    end
    if (emt_cnt[k] >= rcv_cnt[k]) return 1'b0;
    w = act_width();
    n = w * act_height();
    e = emt_cnt[k];
    frame_end = (e / n + 1) * n;
    need = e + w + 2;
    if (need > frame_end) need = frame_end;
    if (rcv_cnt[k] < need) return 1'b0;
    pos = e % n;
    x = longint'(pos % w);
    y = longint'(pos / w);
    c = pass_store[k][e % RING];
    dout = c;
    found = 1'b0;
    // empty black texel: first non-black neighbour, column by column
    if (c[24] && c[23:0] == BLACK) begin
      for (dx = -1; dx <= 1; dx++) begin
        for (dy = -1; dy <= 1; dy++) begin
          nx = x + dx;
          ny = y + dy;
          if (!found && !(dx == 0 && dy == 0) && nx >= 0 && ny >= 0 &&
              nx < longint'(w) && ny < longint'(n / w)) begin
            q = longint'(e) + dy * longint'(w) + dx;
            nb = pass_store[k][q % RING];
            if (nb[23:0] != BLACK) begin
              dout = {c[24], nb[23:0]};
              found = 1'b1;
            end
          end
        end
      end
    end
    emt_cnt[k]++;
    return 1'b1;
  endfunction

  function automatic void predict_dilation(logic kind, color_t color, logic no_surface);
    bit              has;
    logic [24:0]     t;
    longint unsigned n, idx;
    seam_texel_t     r;
    has = (kind == FUNC_TEXEL);
    t = {no_surface, color};
    for (int k = 0; k < PASSES; k++)
      has = dilate_pass(k, has, t, t);
    if (has) begin
      n = longint'(act_width()) * act_height();
      idx = (emt_cnt[PASSES-1] - 1) % n;
      r.color = t[23:0];
      r.last = (idx == n - 1);
      dilated_texels.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every accepted output transaction against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    seam_texel_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (dilated_texels.size() == 0) begin
        $error("unexpected result transaction: out_color %06h, last %0b",
               out_tdata, out_tlast);
        fail_count++;
      end else begin
        want = dilated_texels.pop_front();
        if (out_tdata !== want.color) begin
          $error("out_color mismatch: expected %06h, got %06h", want.color, out_tdata);
          fail_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last_of_frame mismatch: expected %0b, got %0b", want.last, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, switching to a random mode after a random run.
  // A hold-off request freezes tready low for a long hold-off, counted down here.
  // ---------------------------------------------------------------------------
  bit hold_req = 1'b0;

  initial begin : receiver
    int hold_left, mode_left, stall_mode, phase;
    hold_left = 0;
    mode_left = 0;
    stall_mode = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       out_tready <= 1'b1;                          // no stalls
          1:       out_tready <= ($urandom_range(0, 9) < 7);
          2:       out_tready <= ((phase % 7) < 4);             // fixed duty pattern
          default: out_tready <= ($urandom_range(0, 9) < 2);    // mostly stalled
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Every task below starts and ends at a falling edge.
  // Bursts of random length with random gaps while gaps_on is set.
  // ---------------------------------------------------------------------------
  bit gaps_on = 1'b1;
  int burst_left = 0;

  task automatic send_item(logic kind, color_t color, logic no_surface);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {7'b0, no_surface, color};
    do @(posedge clk); while (!in_tready);
    predict_dilation(kind, color, no_surface);
    @(negedge clk);
  endtask

  // flush fields are don't-care, so they carry random bits
  task automatic send_flush();
    send_item(FUNC_FLUSH, color_t'($urandom), 1'($urandom));
  endtask

  // texel mix: lots of empty black texels so that dilation fires often
  task automatic send_texels(int unsigned count, bit noise);
    color_t c;
    logic   ns;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin c = BLACK; ns = 1'b1; end
        5:             begin c = BLACK; ns = 1'b0; end
        6:             begin c = color_t'(1) << $urandom_range(0, 23); ns = 1'($urandom); end
        default:       begin c = color_t'($urandom); ns = 1'($urandom); end
      endcase
      if (noise && $urandom_range(0, 15) == 0) send_flush();
      send_item(FUNC_TEXEL, c, ns);
    end
  endtask

  // only meaningful after whole frames: flushes until every pass is empty
  task automatic drain_passes();
    while (!passes_drained()) send_flush();
  endtask

  // sender pause until all owed results are in, then the pipeline settles
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (dilated_texels.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    burst_left = 0;
  endtask

  // caller makes sure the block is idle first
  task automatic write_reg(cfg_idx_t idx, dim_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = value;
      clear_passes();
    end else if (idx == REG_IMAGE_HEIGHT) begin
      height_reg = value;
      clear_passes();
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Flush with nothing held, then part of a frame at the reset size of 256x256.
  // The next test's register write then throws the held texels away.
  task automatic test_reset_state();
    send_flush();
    send_texels(300, 1'b0);
    wait_idle();
  endtask

  // 3x3 frames picked by hand: corners, black texel with a surface, non-black
  // empty texel, scan order at the center, full-scale colour, an all-empty
  // frame with nothing to take, frames back to back, flushes with junk fields.
  task automatic test_directed_frames();
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    send_item(FUNC_TEXEL, BLACK,        1'b1);  // top-left corner
    send_item(FUNC_TEXEL, 24'hFFFFFF,   1'b0);
    send_item(FUNC_TEXEL, BLACK,        1'b1);  // top-right corner
    send_item(FUNC_TEXEL, 24'h000001,   1'b1);  // empty but coloured: unchanged
    send_item(FUNC_TEXEL, BLACK,        1'b1);  // center: left column scanned first
    send_item(FUNC_TEXEL, BLACK,        1'b0);  // black with surface: stays black
    send_item(FUNC_TEXEL, BLACK,        1'b1);  // bottom-left corner
    send_item(FUNC_TEXEL, 24'h800000,   1'b0);
    send_item(FUNC_TEXEL, BLACK,        1'b1);  // bottom-right, last of frame
    // next frame right away, all empty: nothing to take
    repeat (9) send_item(FUNC_TEXEL, BLACK, 1'b1);
    drain_passes();
    send_flush();                                // flush with nothing ready
    wait_idle();
  endtask

  // Out-of-range and extreme sizes. Frames at the largest sizes are only
  // started; the next register write throws the held texels away.
  task automatic test_extreme_sizes();
    // zero width and height act as 1: every texel is a frame on its own
    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, '0);
    send_texels(4, 1'b0);
    drain_passes();
    wait_idle();
    // width past the limit acts as the full width: one row, all texels held
    write_reg(REG_IMAGE_WIDTH, {DIM_W{1'b1}});
    write_reg(REG_IMAGE_HEIGHT, 1);
    send_texels(EXTREME_TEXELS, 1'b0);
    wait_idle();
    // one column, height past the limit acts as 4096 rows: texels stream out
    write_reg(REG_IMAGE_WIDTH, 1);
    write_reg(REG_IMAGE_HEIGHT, {DIM_W{1'b1}});
    send_texels(EXTREME_TEXELS, 1'b0);
    wait_idle();
    // two full-width rows
    write_reg(REG_IMAGE_WIDTH, dim_t'(MAX_W));
    write_reg(REG_IMAGE_HEIGHT, 2);
    send_texels(EXTREME_TEXELS, 1'b0);
    wait_idle();
  endtask

  // Writes past the last register index must leave a frame in flight alone.
  task automatic test_unused_index();
    write_reg(REG_IMAGE_WIDTH, 5);
    write_reg(REG_IMAGE_HEIGHT, 4);
    send_texels(7, 1'b0);
    wait_idle();
    write_reg(REG_UNUSED_2, dim_t'($urandom));
    write_reg(REG_UNUSED_3, dim_t'($urandom));
    send_texels(13, 1'b0);
    drain_passes();
    wait_idle();
  endtask

  // Long receiver hold-off while the sender keeps offering: input must stall.
  // Then a full sender pause before one more frame.
  task automatic test_output_stall();
    write_reg(REG_IMAGE_WIDTH, 6);
    write_reg(REG_IMAGE_HEIGHT, 5);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    send_texels(180, 1'b0);   // six frames back to back
    drain_passes();
    wait_idle();
    send_texels(30, 1'b0);
    drain_passes();
    gaps_on = 1'b1;
    wait_idle();
  endtask

  // Random sizes, mostly whole frames with random content; some frames are cut
  // short and thrown away by the next write, some carry stray flushes.
  task automatic test_random_frames();
    int unsigned sent, frames, f, n, cut, w, h;
    bit broken, noise;
    sent = 0;
    while (sent < RANDOM_TEXELS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin w = $urandom_range(1, 16); h = $urandom_range(1, 10); end
        7:                   begin w = $urandom_range(1, 3);  h = $urandom_range(8, 40); end
        8:                   begin w = $urandom_range(17, 64); h = $urandom_range(1, 4); end
        default:             begin w = $urandom_range(1, 8);  h = 1; end
      endcase
      case ($urandom_range(0, 2))
        0: begin
          write_reg(REG_IMAGE_WIDTH, dim_t'(w));
          write_reg(REG_IMAGE_HEIGHT, dim_t'(h));
        end
        1:       write_reg(REG_IMAGE_WIDTH, dim_t'(w));
        default: write_reg(REG_IMAGE_HEIGHT, dim_t'(h));
      endcase
      // a single write may leave a large frame: set both sizes then
      if (act_width() * act_height() > RANDOM_FRAME_MAX) begin
        write_reg(REG_IMAGE_WIDTH, dim_t'(w));
        write_reg(REG_IMAGE_HEIGHT, dim_t'(h));
      end
      gaps_on = ($urandom_range(0, 3) != 0);
      noise = ($urandom_range(0, 3) == 0);
      frames = $urandom_range(1, 4);
      broken = 1'b0;
      for (f = 0; f < frames && !broken && sent < RANDOM_TEXELS; f++) begin
        n = act_width() * act_height();
        if (n > 1 && $urandom_range(0, 11) == 0) begin
          cut = $urandom_range(1, n - 1);
          send_texels(cut, noise);
          sent += cut;
          broken = 1'b1;
        end else begin
          send_texels(n, noise);
          sent += n;
          if ($urandom_range(0, 1)) drain_passes();
          if ($urandom_range(0, 5) == 0) wait_idle();
        end
      end
      wait_idle();
    end
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main
    int guard;
    clear_passes();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_state();
    test_directed_frames();
    test_extreme_sizes();
    test_unused_index();
    test_output_stall();
    test_random_frames();

    // everything sent: wait out the owed results, then watch for strays
    in_tvalid <= 1'b0;
    guard = 0;
    while (dilated_texels.size() != 0 && guard < END_GUARD) begin
      @(negedge clk);
      guard++;
    end
    if (dilated_texels.size() != 0) begin
      $error("%0d expected results never arrived", dilated_texels.size());
      fail_count++;
    end
    repeat (LATENCY + 8) @(negedge clk);

    if (fail_count == 0) begin
      $display("lightmap_seam_dilation verification clean");
    end else begin
      $display("lightmap_seam_dilation verification failed");
    end
    $finish;
  end

  // watchdog: a hung handshake ends the run here
  initial begin : watchdog
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("lightmap_seam_dilation verification failed");
    $finish;
  end

endmodule

`default_nettype wire
